// ===== src/xbf_pkg.sv =====
`default_nettype none

package xbf_pkg;

   typedef enum logic [1:0] {
      OP_PAYLOAD = 2'd0,
      OP_PAD     = 2'd1,
      OP_EOT     = 2'd2,
      OP_CANCEL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_SUM_128 = 2'd0,
      MODE_CRC_128 = 2'd1,
      MODE_CRC_1K  = 2'd2,
      MODE_CRC_1K_ALT = 2'd3
   } mode_type;

   localparam logic [7:0]  CHAR_SOH = 8'h01;
   localparam logic [7:0]  CHAR_STX = 8'h02;
   localparam logic [7:0]  CHAR_EOT = 8'h04;
   localparam logic [7:0]  CHAR_CAN = 8'h18;
   localparam logic [7:0]  CHAR_PAD = 8'h1A;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [10:0] SIZE_SMALL = 11'd128;
   localparam logic [10:0] SIZE_LARGE = 11'd1024;

   // One accepted request worth of line bytes, emitted from index 0 up to last_idx.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            done;
   } job_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {d, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/xmodem_block_framer.sv =====
// XMODEM sender block framer.
// Requests enter on req_* (tuser = operation, tdata = payload and block number).
// Each request produces one to four line bytes on rsp_* (tdata = byte,
// tlast = last byte of this request, tuser = frame done). A payload or pad
// request at the start of a block adds the header, block number and its
// complement; the request that fills the block adds the checksum or the
// CRC-16 (high byte first). EOT sends one byte, cancel sends two.
// csr_wen/csr_wdata write frame_mode; write it only while the block is idle.
// An accepted request's byte group is registered in the queue; its first
// byte shows on rsp when it reaches the head. One request per cycle is taken
// while each yields a single byte and rsp_tready stays high; a longer request
// holds the channel while the head serializer sends one byte per ready cycle.
// req_tready drops only when the QUEUE_DEPTH-entry queue is full, so the
// front keeps accepting while a finished byte waits on a stalled receiver.
// Reset: frame_mode returns to 1 (128-byte CRC), block position and
// accumulators clear, and the queue empties.
`default_nettype none

module xmodem_block_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // config
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata,      // frame_mode
   // requests
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,      // [7:0] payload_byte, [15:8] block_number
   input  wire logic [1:0]  req_tuser,      // [1:0] operation
   // line bytes
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,      // [7:0] line_byte
   output logic             rsp_tlast,      // last_of_run
   output logic             rsp_tuser       // [0] frame_done
);

   logic               accept;
   logic               full;
   logic               pop;
   xbf_pkg::job_type   job;
   xbf_pkg::head_type  head;

   // Accept whenever the queue has room.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   xbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .operation    (req_tuser),
      .payload_byte (req_tdata[7:0]),
      .block_number (req_tdata[15:8]),
      .job          (job)
   );

   xbf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (job),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   xbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== src/xbf_front.sv =====
`default_nettype none

// Classify each request, advance block state and build its byte group.
module xbf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_wdata,
   input  wire logic             accept,
   input  wire logic [1:0]       operation,
   input  wire logic [7:0]       payload_byte,
   input  wire logic [7:0]       block_number,
   output xbf_pkg::job_type      job
);

   logic [1:0]  mode_ff, mode_in;
   logic [10:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;

   logic        big;
   logic        start;
   logic        block_end;
   logic [7:0]  data_byte;
   logic [15:0] crc_base, crc_next;
   logic [7:0]  sum_base, sum_next;
   logic [10:0] pos_next;
   logic [10:0] size;
   xbf_pkg::op_type op;

   assign op        = xbf_pkg::op_type'(operation);
   assign big       = mode_ff[1];
   assign size      = big ? xbf_pkg::SIZE_LARGE : xbf_pkg::SIZE_SMALL;
   assign start     = (pos_ff == 11'd0);
   assign data_byte = (op == xbf_pkg::OP_PAD) ? xbf_pkg::CHAR_PAD : payload_byte;
   assign crc_base  = start ? 16'd0 : crc_ff;
   assign sum_base  = start ? 8'd0 : sum_ff;
   assign crc_next  = xbf_pkg::crc_step(crc_base, data_byte);
   assign sum_next  = sum_base + data_byte;
   assign pos_next  = pos_ff + 11'd1;
   assign block_end = (pos_next >= size);

   always_comb begin
      job     = '0;
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      sum_in  = sum_ff;
      mode_in = csr_wen ? csr_wdata : mode_ff;
      case (op)
         xbf_pkg::OP_EOT: begin
            job.bytes[0] = xbf_pkg::CHAR_EOT;
            job.last_idx = 2'd0;
            job.done     = 1'b1;
         end
         xbf_pkg::OP_CANCEL: begin
            job.bytes[0] = xbf_pkg::CHAR_CAN;
            job.bytes[1] = xbf_pkg::CHAR_CAN;
            job.last_idx = 2'd1;
            job.done     = 1'b1;
         end
         default: begin
            if (start) begin
               // A block's first byte never closes it: sizes start at 128.
               job.bytes[0] = big ? xbf_pkg::CHAR_STX : xbf_pkg::CHAR_SOH;
               job.bytes[1] = block_number;
               job.bytes[2] = ~block_number;
               job.bytes[3] = data_byte;
               job.last_idx = 2'd3;
            end else begin
               job.bytes[0] = data_byte;
               job.last_idx = 2'd0;
               if (block_end) begin
                  job.done = 1'b1;
                  if (mode_ff == xbf_pkg::MODE_SUM_128) begin
                     job.bytes[1] = sum_next;
                     job.last_idx = 2'd1;
                  end else begin
                     job.bytes[1] = crc_next[15:8];
                     job.bytes[2] = crc_next[7:0];
                     job.last_idx = 2'd2;
                  end
               end
            end
         end
      endcase

      if (accept) begin
         if ((op == xbf_pkg::OP_EOT) || (op == xbf_pkg::OP_CANCEL) || block_end) begin
            pos_in = 11'd0;
            crc_in = 16'd0;
            sum_in = 8'd0;
         end else begin
            pos_in = pos_next;
            crc_in = crc_next;
            sum_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= xbf_pkg::MODE_CRC_128;
         pos_ff  <= 11'd0;
         crc_ff  <= 16'd0;
         sum_ff  <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/xbf_queue.sv =====
`default_nettype none

// Short queue of byte groups between front and back.
module xbf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire xbf_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output xbf_pkg::head_type     head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   xbf_pkg::job_type  entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== src/xbf_back.sv =====
`default_nettype none

// Serialize the head byte group onto the response channel.
module xbf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire xbf_pkg::head_type head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       at_last;

   assign at_last    = (idx_ff == head.job.last_idx);
   assign rsp_tvalid = head.valid;
   assign rsp_tdata  = head.job.bytes[idx_ff];
   assign rsp_tlast  = at_last;
   assign rsp_tuser  = at_last && head.job.done;
   assign pop        = head.valid && rsp_tready && at_last;

   always_comb begin
      idx_in = idx_ff;
      if (head.valid && rsp_tready) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/tb_xmodem_block_framer.sv =====
`default_nettype none

module tb_xmodem_block_framer;

   // Quiet cycles allowed before the run is declared hung. The slowest legal
   // gap comes from the 84% stall on either side.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // One request as queued for the driver.
   typedef struct packed {
      xbf_pkg::op_type op;
      logic [7:0]      data;
      logic [7:0]      blk;
   } request_type;

   // One line byte as the framer should emit it.
   typedef struct packed {
      logic [7:0] value;
      logic       done;
      logic       last;
   } line_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_wdata  = 2'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'd0;
   logic [1:0]  req_tuser  = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   request_type pending_q[$];   // requests waiting for the driver
   line_type    line_q[$];      // line bytes owed by the framer, oldest first
   request_type on_bus;         // request currently held on req_*

   // Framer state as predicted here. line_mode only changes while drained.
   xbf_pkg::mode_type line_mode = xbf_pkg::MODE_CRC_128;
   logic [10:0] blk_pos   = '0;
   logic [15:0] blk_crc   = '0;
   logic [7:0]  blk_sum   = '0;

   // Block position as seen by the stimulus planner, which runs ahead.
   int plan_pos = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int errors         = 0;
   int req_count      = 0;
   int byte_count     = 0;
   int frame_count    = 0;
   int quiet_cycles   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   xmodem_block_framer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),      // [7:0] payload_byte, [15:8] block_number
      .req_tuser  (req_tuser),      // [1:0] operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),      // [7:0] line_byte
      .rsp_tlast  (rsp_tlast),      // last_of_run
      .rsp_tuser  (rsp_tuser)       // [0] frame_done
   );

   // Payload bytes per block in the current mode; mode 3 behaves as 1K.
   function automatic int block_len();
      return (line_mode == xbf_pkg::MODE_CRC_1K || line_mode == xbf_pkg::MODE_CRC_1K_ALT) ?
             1024 : 128;
   endfunction

   // CRC-16/XMODEM, one data bit per step, MSB first.
   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         if (r[15] ^ b[k]) begin
            r = {r[14:0], 1'b0} ^ xbf_pkg::CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Work out the line bytes one accepted request causes and queue them.
   task automatic frame_request(input request_type rq);
      line_type   run [4];
      int         n;
      logic       big;
      logic [7:0] d;
      n = 0;
      big = (block_len() == 1024);
      if (rq.op == xbf_pkg::OP_EOT || rq.op == xbf_pkg::OP_CANCEL) begin
         // Abandon any partial block; no check bytes go out.
         blk_pos = '0;
         if (rq.op == xbf_pkg::OP_EOT) begin
            run[0] = '{xbf_pkg::CHAR_EOT, 1'b1, 1'b0};
            n = 1;
         end else begin
            run[0] = '{xbf_pkg::CHAR_CAN, 1'b0, 1'b0};
            run[1] = '{xbf_pkg::CHAR_CAN, 1'b1, 1'b0};
            n = 2;
         end
      end else begin
         d = (rq.op == xbf_pkg::OP_PAD) ? xbf_pkg::CHAR_PAD : rq.data;
         if (blk_pos == 0) begin
            // Open a block: header, number, complement. Number is taken here only.
            blk_crc = '0;
            blk_sum = '0;
            run[0] = '{big ? xbf_pkg::CHAR_STX : xbf_pkg::CHAR_SOH, 1'b0, 1'b0};
            run[1] = '{rq.blk, 1'b0, 1'b0};
            run[2] = '{~rq.blk, 1'b0, 1'b0};
            n = 3;
         end
         run[n] = '{d, 1'b0, 1'b0};
         n++;
         blk_crc = crc16_next(blk_crc, d);
         blk_sum = blk_sum + d;
         blk_pos = blk_pos + 11'd1;
         // Length and check type follow the mode at this byte, not at the header.
         if (blk_pos >= block_len()) begin
            if (line_mode == xbf_pkg::MODE_SUM_128) begin
               run[n] = '{blk_sum, 1'b1, 1'b0};
               n++;
            end else begin
               run[n]     = '{blk_crc[15:8], 1'b0, 1'b0};
               run[n + 1] = '{blk_crc[7:0], 1'b1, 1'b0};
               n += 2;
            end
            blk_pos = '0;
         end
      end
      for (int i = 0; i < n; i++) begin
         run[i].last = (i == n - 1);
         line_q.push_back(run[i]);
      end
   endtask

   // Driver: hold the request until accepted, then advance or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_request(on_bus);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.op;
               req_tdata  <= {on_bus.blk, on_bus.data};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted line byte with the oldest one owed.
   always @(posedge clock) begin : monitor
      line_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            byte_count++;
            if (rsp_tuser) begin
               frame_count++;
            end
            if (line_q.size() == 0) begin
               if (errors < REPORT_LIMIT) begin
                  $display("unexpected line byte %h done %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               end
               errors++;
            end else begin
               want = line_q.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.done ||
                   rsp_tlast !== want.last) begin
                  if (errors < REPORT_LIMIT) begin
                     $display({"line byte mismatch: expected %h done %b last %b,",
                               " got %h done %b last %b"},
                              want.value, want.done, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  end
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: drop the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Queue one request and track where the block will stand after it.
   task automatic plan_request(input xbf_pkg::op_type op, input logic [7:0] data,
                               input logic [7:0] blk);
      pending_q.push_back('{op, data, blk});
      if (op == xbf_pkg::OP_EOT || op == xbf_pkg::OP_CANCEL) begin
         plan_pos = 0;
      end else begin
         plan_pos++;
         if (plan_pos >= block_len()) begin
            plan_pos = 0;
         end
      end
   endtask

   // Wait until every request is accepted and every line byte has arrived.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_q.size() != 0 || req_tvalid || line_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Drain, write frame_mode, then set the idle pattern for the next phase.
   task automatic begin_phase(input xbf_pkg::mode_type m, input int snd, input int rcv);
      wait_drained();
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      line_mode = m;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      send_idle_pct  = snd;
      recv_stall_pct = rcv;
   endtask

   // Mostly runs toward the end of the open block with random content and often a
   // padded tail, cut at the budget so a block may carry into the next phase
   // and close under another mode; the rest is stray EOT/cancel and short
   // blocks cut off by an abort.
   task automatic fill_random(input int budget);
      int added;
      int r;
      int n;
      int pad_at;
      added = 0;
      while (added < budget) begin
         r = $urandom_range(99);
         if (r < 2) begin
            plan_request(r < 1 ? xbf_pkg::OP_EOT : xbf_pkg::OP_CANCEL,
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            added++;
         end else if (r < 5) begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) begin
               plan_request($urandom_range(3) == 0 ? xbf_pkg::OP_PAD : xbf_pkg::OP_PAYLOAD,
                            8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            plan_request($urandom_range(1) ? xbf_pkg::OP_EOT : xbf_pkg::OP_CANCEL,
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            added += n + 1;
         end else begin
            n = block_len() - plan_pos;
            if (n > budget - added) begin
               n = budget - added;
            end
            pad_at = $urandom_range(1) ? n : $urandom_range(n - 1);
            for (int i = 0; i < n; i++) begin
               plan_request((i >= pad_at || $urandom_range(19) == 0) ?
                            xbf_pkg::OP_PAD : xbf_pkg::OP_PAYLOAD,
                            8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            added += n;
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset mode first, extremes of data and block number, every
      // operation both inside a block and at its start.
      plan_request(xbf_pkg::OP_PAYLOAD, 8'h00, 8'h00);
      plan_request(xbf_pkg::OP_PAYLOAD, 8'hFF, 8'hFF);   // number ignored mid-block
      plan_request(xbf_pkg::OP_PAD,     8'h55, 8'h00);
      plan_request(xbf_pkg::OP_EOT,     8'hAA, 8'h55);   // abandon partial block
      plan_request(xbf_pkg::OP_EOT,     8'h00, 8'h00);
      plan_request(xbf_pkg::OP_PAD,     8'h00, 8'hFF);
      plan_request(xbf_pkg::OP_CANCEL,  8'hFF, 8'hFF);
      plan_request(xbf_pkg::OP_CANCEL,  8'h00, 8'h00);
      plan_request(xbf_pkg::OP_PAYLOAD, 8'h80, 8'h7F);
      // Switch to checksum with a block open; EOT then abandons the block unclosed.
      begin_phase(xbf_pkg::MODE_SUM_128, 0, 0);
      plan_request(xbf_pkg::OP_PAYLOAD, 8'h01, 8'h01);
      plan_request(xbf_pkg::OP_EOT,     8'hFF, 8'hFF);
      // Mode three acts as 1K CRC.
      begin_phase(xbf_pkg::MODE_CRC_1K_ALT, 0, 0);
      plan_request(xbf_pkg::OP_PAYLOAD, 8'hFF, 8'h00);
      plan_request(xbf_pkg::OP_CANCEL,  8'h00, 8'h00);
      begin_phase(xbf_pkg::MODE_CRC_1K, 0, 0);
      plan_request(xbf_pkg::OP_PAD,     8'hFF, 8'hAA);
      plan_request(xbf_pkg::OP_EOT,     8'h00, 8'h00);

      // Random phases over the idle patterns; blocks close under both checks.
      begin_phase(xbf_pkg::MODE_SUM_128, 0, 0);
      fill_random(70);
      begin_phase(xbf_pkg::MODE_CRC_128, 84, 0);
      fill_random(70);
      begin_phase(xbf_pkg::MODE_CRC_128, 0, 84);
      fill_random(60);
      begin_phase(xbf_pkg::MODE_SUM_128, 9, 9);
      fill_random(60);

      // Open a 1K block past 128 bytes, then shrink the mode: the next byte
      // closes the block at once with a checksum.
      begin_phase(xbf_pkg::MODE_CRC_1K, 0, 0);
      plan_request(xbf_pkg::OP_EOT, 8'h00, 8'h00);
      repeat (130) begin
         plan_request(xbf_pkg::OP_PAYLOAD, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
      end
      begin_phase(xbf_pkg::MODE_SUM_128, 9, 9);
      plan_request(xbf_pkg::OP_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
      fill_random(10);

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Covered %0d requests in all four frame modes, %0d line bytes, %0d frames closed.",
               req_count, byte_count, frame_count);
      $display("Idle patterns: none, sender 84%%, receiver 84%%, both 9%%; %0d errors.", errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
